### hdl/ile_pkg.sv
package ile_pkg;

   localparam int CAPACITY = 16;
   localparam int POS_W = 5;
   localparam int CNT_W = 5;
   localparam int DATA_W = 32;
   localparam int HC_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (POS_W > HC_W) ? POS_W : HC_W;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_GET    = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      req_kind_type              req_type;
      logic [POS_W-1:0]          position;
      logic signed [DATA_W-1:0]  value;
   } req_word_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  read_data;
      logic [CNT_W-1:0]          count;
   } rsp_word_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic execute;
   } cmd_type;

endpackage

### hdl/ile_ctrl.sv
module ile_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ile_pkg::cmd_type cmd
);

   ile_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ile_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ile_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ile_pkg::S_EXEC;
            end
         end
         ile_pkg::S_EXEC: begin
            cmd.execute = 1'b1;
            state_in = ile_pkg::S_RESP;
         end
         ile_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            if (!rsp_stall) begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ile_pkg::S_EXEC;
               end else begin
                  state_in = ile_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = ile_pkg::S_IDLE;
         end
      endcase
   end

endmodule

### hdl/ile_datapath.sv
module ile_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ile_pkg::cmd_type      cmd,
   input  ile_pkg::req_word_type req_word,
   output ile_pkg::rsp_word_type rsp_word
);

   ile_pkg::req_word_type req_ff, req_in;
   ile_pkg::rsp_word_type rsp_ff, rsp_in;
   logic signed [ile_pkg::DATA_W-1:0] entries_ff [ile_pkg::CAPACITY];
   logic signed [ile_pkg::DATA_W-1:0] entries_in [ile_pkg::CAPACITY];
   logic [ile_pkg::HC_W-1:0] held_ff, held_in;
   logic [ile_pkg::CMP_W-1:0] pos_ext, held_ext;
   logic signed [ile_pkg::DATA_W-1:0] sel_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      entries_ff <= entries_in;
   end

   assign pos_ext  = ile_pkg::CMP_W'(req_ff.position);
   assign held_ext = ile_pkg::CMP_W'(held_ff);

   always_comb begin
      sel_data = '0;
      for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
         if (pos_ext == ile_pkg::CMP_W'(i)) begin
            sel_data = entries_ff[i];
         end
      end
   end

   always_comb begin
      req_in = cmd.load ? req_word : req_ff;
      rsp_in = rsp_ff;
      entries_in = entries_ff;
      held_in = held_ff;
      if (cmd.execute) begin
         rsp_in.read_data = '0;
         rsp_in.status = ile_pkg::ST_RANGE;
         unique case (req_ff.req_type)
            ile_pkg::REQ_INSERT: begin
               if (pos_ext > held_ext) begin
                  rsp_in.status = ile_pkg::ST_RANGE;
               end else if (held_ext == ile_pkg::CMP_W'(ile_pkg::CAPACITY)) begin
                  rsp_in.status = ile_pkg::ST_FULL;
               end else begin
                  rsp_in.status = ile_pkg::ST_OK;
                  for (int i = 1; i < ile_pkg::CAPACITY; i++) begin
                     if (ile_pkg::CMP_W'(i) > pos_ext) begin
                        entries_in[i] = entries_ff[i-1];
                     end
                  end
                  for (int i = 0; i < ile_pkg::CAPACITY; i++) begin
                     if (ile_pkg::CMP_W'(i) == pos_ext) begin
                        entries_in[i] = req_ff.value;
                     end
                  end
                  held_in = held_ff + ile_pkg::HC_W'(1);
               end
            end
            ile_pkg::REQ_REMOVE: begin
               if (pos_ext < held_ext) begin
                  rsp_in.status = ile_pkg::ST_OK;
                  for (int i = 0; i < ile_pkg::CAPACITY - 1; i++) begin
                     if (ile_pkg::CMP_W'(i) >= pos_ext) begin
                        entries_in[i] = entries_ff[i+1];
                     end
                  end
                  held_in = held_ff - ile_pkg::HC_W'(1);
               end
            end
            ile_pkg::REQ_GET: begin
               if (pos_ext < held_ext) begin
                  rsp_in.status = ile_pkg::ST_OK;
                  rsp_in.read_data = sel_data;
               end
            end
            default: begin
               rsp_in.status = ile_pkg::ST_RANGE;
            end
         endcase
         rsp_in.count = ile_pkg::CNT_W'(held_in);
      end
   end

   assign rsp_word = rsp_ff;

endmodule

### hdl/indexed_list_engine_unit.sv
// Indexed list engine: holds an ordered list of up to CAPACITY signed 32-bit
// words in a chain of registers. Each request (insert, remove or get at a
// position) yields exactly one response word carrying status, read data and
// the count after the request. A request is first captured in a register;
// then, in the execute state, the register chain shifts all entries at once
// and the response is registered. The next request is taken in the same
// cycle the response is taken; none is taken while a response is pending.
module indexed_list_engine_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ile_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ile_pkg::rsp_word_type rsp_word
);

   ile_pkg::cmd_type cmd;

   ile_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ile_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule

### hdl/ile_checker.sv
module ile_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input ile_pkg::rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response shown in execute cycle");

   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##2 rsp_valid)
      else $error("response missing two cycles after request");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response pending");

endmodule

bind indexed_list_engine_unit ile_checker u_ile_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
